>>> hw/rtl/htlp_pkg.sv
// Shared types and constants for the linear-probing hash table.
// Used by htlp_hash and hash_table_linear_probe; no dependencies.
`default_nettype none
package htlp_pkg;
  localparam int TABLE_SIZE = 64;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int COUNT_W    = SLOT_W + 1;
  localparam int KEY_BYTES  = 32;
  localparam int KEY_BITS   = KEY_BYTES * 8;
  localparam int LEN_W      = 6;
  localparam int VALUE_W    = 32;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [25:0] FOLD_MUL  = 26'd39;
  localparam logic [25:0] FOLD_MOD  = 26'd1000000;
  // floor(2^36 / 1000000); the quotient estimate is low by at most one.
  localparam logic [42:0] FOLD_RECIP = 43'd68719;
  localparam int          RECIP_SHIFT = 36;
  // Reciprocal golden ratio in Q0.48, split into two 24-bit halves.
  localparam logic [43:0] GOLD_HI = 44'h9E3779;
  localparam logic [43:0] GOLD_LO = 44'hB97F4A;

  typedef struct packed {
    logic [1:0]         command;
    logic [63:0]        key_word0;
    logic [63:0]        key_word1;
    logic [63:0]        key_word2;
    logic [63:0]        key_word3;
    logic [LEN_W-1:0]   key_length;
    logic [VALUE_W-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic               success;
    logic [5:0]         slot_index;
    logic [VALUE_W-1:0] found_value;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [SLOT_W-1:0]   home;
    logic [KEY_BITS-1:0] key;
  } hash_res_t;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_W-1:0]  value;
  } row_t;
endpackage
`default_nettype wire

>>> hw/rtl/htlp_hash.sv
// Key normalization and home slot computation, one key byte per fold pass.
// Depends on htlp_pkg.
`default_nettype none
module htlp_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [htlp_pkg::KEY_BITS-1:0] key,
  input  logic [htlp_pkg::LEN_W-1:0]    key_length,
  output logic                          done,
  output htlp_pkg::hash_res_t           res
);
  import htlp_pkg::*;

  typedef enum logic [6:0] {
    H_IDLE = 7'b0000001,
    H_SCAN = 7'b0000010,
    H_QUO  = 7'b0000100,
    H_RED  = 7'b0001000,
    H_MULA = 7'b0010000,
    H_MULB = 7'b0100000,
    H_DONE = 7'b1000000
  } hstate_t;

  hstate_t             state;
  logic [KEY_BITS-1:0] kbuf;
  logic [LEN_W-1:0]    n;
  logic [LEN_W-1:0]    idx;
  logic [19:0]         h;
  logic [25:0]         t;
  logic [5:0]          q;
  logic [43:0]         plo;
  logic [23:0]         phi;

  logic [7:0]          cur_byte;
  logic [42:0]         qprod;
  logic [25:0]         r;
  logic [43:0]         hprod;
  logic [47:0]         frac;
  logic [KEY_BITS-1:0] mask;

  assign cur_byte = kbuf[idx[4:0]*8 +: 8];
  assign qprod    = 43'(t) * FOLD_RECIP;
  assign r        = t - 26'(q) * FOLD_MOD;
  assign hprod    = 44'(h) * GOLD_HI;
  assign frac     = {phi, 24'b0} + {4'b0, plo};

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      mask[b*8 +: 8] = (LEN_W'(b) < idx) ? 8'hFF : 8'h00;
    end
  end

  assign done     = (state == H_DONE);
  assign res.len  = idx;
  assign res.home = frac[47 -: SLOT_W];
  assign res.key  = kbuf & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (start) begin
            kbuf  <= key;
            n     <= (key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length;
            idx   <= '0;
            h     <= '0;
            state <= H_SCAN;
          end
        end
        H_SCAN: begin
          // The effective length ends at the first zero byte.
          if (idx < n && cur_byte != 8'd0) begin
            t     <= 26'(h) * FOLD_MUL + 26'(cur_byte);
            state <= H_QUO;
          end else begin
            state <= H_MULA;
          end
        end
        H_QUO: begin
          q     <= qprod[RECIP_SHIFT +: 6];
          state <= H_RED;
        end
        H_RED: begin
          h     <= (r >= FOLD_MOD) ? 20'(r - FOLD_MOD) : r[19:0];
          idx   <= idx + LEN_W'(1);
          state <= H_SCAN;
        end
        H_MULA: begin
          plo   <= 44'(h) * GOLD_LO;
          state <= H_MULB;
        end
        H_MULB: begin
          phi   <= hprod[23:0];
          state <= H_DONE;
        end
        H_DONE: begin
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (state != H_IDLE) |-> (idx <= n && n <= LEN_W'(KEY_BYTES)))
    else $error("hash byte index past key length");
  a_h_range: assert property (@(posedge clk) disable iff (rst)
    (state == H_SCAN) |-> (h < 20'(FOLD_MOD)))
    else $error("fold value not reduced");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("hash done held");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/hash_table_linear_probe.sv
// Open-addressed hash table with linear probing and tombstones.
// Command channel cmd_valid/cmd_stall/cmd_data, result channel
// res_valid/res_stall/res_data; a transfer happens when valid is high and
// stall is low. Each command gives exactly one result.
// The key hash runs a serial fold with a reciprocal-based modulo: for each
// effective key byte it scans, forms the quotient and reduces, then it
// multiplies by the golden ratio. Probing then checks flags only for a put,
// and for get and remove reads the slot memory (registered) and then
// compares, at most 64 slots. One command is in work at a time.
// cmd_stall is low only when no command is in work. A finished result sits
// in the output register; if the receiver stalls, the next command may
// still be taken and waits at its end until the register frees.
// Reset (rst, synchronous) clears occupancy and tombstone flags and empties
// the output register; slot memory contents need no clearing.
// Depends on htlp_pkg and htlp_hash.
`default_nettype none
module hash_table_linear_probe (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  htlp_pkg::cmd_t  cmd_data,
  output logic            res_valid,
  input  logic            res_stall,
  output htlp_pkg::res_t  res_data
);
  import htlp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CMP   = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t              state;
  logic [1:0]          cmd;
  logic [VALUE_W-1:0]  value;
  logic [LEN_W-1:0]    klen;
  logic [KEY_BITS-1:0] kkey;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count;
  logic [TABLE_SIZE-1:0] occ;
  logic [TABLE_SIZE-1:0] tomb;

  logic                p_success;
  logic [SLOT_W-1:0]   p_slot;
  logic [VALUE_W-1:0]  p_value;

  row_t                mem [TABLE_SIZE];
  row_t                rd_row;
  logic                rd_en;
  logic                wr_en;

  logic                cmd_fire;
  logic                hash_done;
  hash_res_t           hres;
  logic                key_hit;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign key_hit   = (rd_row.len == klen) && (rd_row.key == kkey);
  assign rd_en     = (state == S_PROBE) && (cmd != CMD_PUT) &&
                     (count != COUNT_W'(TABLE_SIZE));
  assign wr_en     = (state == S_PROBE) && (cmd == CMD_PUT) &&
                     (count != COUNT_W'(TABLE_SIZE)) && (!occ[slot] || tomb[slot]);

  htlp_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd_fire),
    .key        ({cmd_data.key_word3, cmd_data.key_word2,
                  cmd_data.key_word1, cmd_data.key_word0}),
    .key_length (cmd_data.key_length),
    .done       (hash_done),
    .res        (hres)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= '{len: klen, key: kkey, value: value};
    end
    if (rd_en) begin
      rd_row <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      tomb      <= '0;
      res_valid <= 1'b0;
    end else begin
      // In S_RESP the output register is reloaded below instead.
      if (res_valid && !res_stall && state != S_RESP) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            cmd   <= cmd_data.command;
            value <= cmd_data.entry_value;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            klen      <= hres.len;
            kkey      <= hres.key;
            slot      <= hres.home;
            count     <= '0;
            p_success <= 1'b0;
            p_slot    <= '0;
            p_value   <= '0;
            if (cmd == CMD_PUT || cmd == CMD_GET || cmd == CMD_REMOVE) begin
              state <= S_PROBE;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_PROBE: begin
          if (count == COUNT_W'(TABLE_SIZE)) begin
            state <= S_RESP;
          end else if (cmd == CMD_PUT) begin
            if (wr_en) begin
              occ[slot]  <= 1'b1;
              tomb[slot] <= 1'b0;
              p_success  <= 1'b1;
              p_slot     <= slot;
              state      <= S_RESP;
            end else begin
              slot  <= slot + SLOT_W'(1);
              count <= count + COUNT_W'(1);
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // An empty slot ends the search; tombstones are walked past.
          if (!occ[slot]) begin
            state <= S_RESP;
          end else if (!tomb[slot] && key_hit) begin
            p_success <= 1'b1;
            p_slot    <= slot;
            if (cmd == CMD_GET) begin
              p_value <= rd_row.value;
            end else begin
              tomb[slot] <= 1'b1;
            end
            state <= S_RESP;
          end else begin
            slot  <= slot + SLOT_W'(1);
            count <= count + COUNT_W'(1);
            state <= S_PROBE;
          end
        end
        S_RESP: begin
          if (!res_valid || !res_stall) begin
            res_data.success     <= p_success;
            res_data.slot_index  <= 6'(p_slot);
            res_data.found_value <= p_value;
            res_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_hash: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (state == S_HASH))
    else $error("accepted command did not start hashing");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_CMP) |-> (count <= COUNT_W'(TABLE_SIZE)))
    else $error("probe count past one turn");
  a_put_marks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (occ[$past(slot)] && !tomb[$past(slot)]))
    else $error("put did not mark slot live");
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && p_success) |-> 1'b0)
    else $error("compare reached after success");
`endif
endmodule
`default_nettype wire
